// ----- rtl/mlsbm_pkg.sv -----
// ----------------------------------------------------------------------------
// mlsbm_pkg
// shared types and constants for the led state and blink manager
// ----------------------------------------------------------------------------
package mlsbm_pkg;

    localparam int LED_COUNT_DEF = 64;
    localparam logic [15:0] PERIOD_RESET = 16'd500;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [7:0] MAP_UNASSIGNED = 8'h80;

    localparam logic [1:0] MODE_EVENT = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic [1:0] REG_BLINK_EN = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;

    localparam logic [4:0] ST_CONST_ON = 5'h01;
    localparam logic [4:0] ST_BLINK = 5'h02;
    localparam logic [4:0] ST_ACTIVE = 5'h04;
    localparam logic [4:0] ST_REMEMBER = 5'h08;
    localparam logic [4:0] ST_PHASE = 5'h10;
    localparam logic [4:0] ST_RESTORE_C = 5'h0D;
    localparam logic [4:0] ST_RESTORE_BOFF = 5'h05;
    localparam logic [4:0] ST_RESTORE_OFF = 5'h16;
    localparam logic [4:0] ST_MASK_BOFF = 5'h15;
    localparam logic [4:0] ST_MASK_OFF = 5'h16;
    localparam logic [4:0] ST_NO_PHASE = 5'h0F;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_UPD,
        S_CHECK,
        S_OUT
    } ctl_state_t;

    function automatic logic state_lit(input logic [4:0] s);
        return s == 5'h05 || s == 5'h15 || s == 5'h16 || s == 5'h1D
            || s == 5'h0D || s == 5'h17;
    endfunction

    function automatic logic [4:0] apply_event(input logic [4:0] s_in,
                                               input logic on,
                                               input logic blink);
        logic [4:0] s;
        s = s_in;
        if (on)
        begin
            if (!blink && s[1])
                s = ST_RESTORE_C;
            else
                s = s | (blink ? (ST_BLINK | ST_ACTIVE | ST_PHASE)
                               : (ST_CONST_ON | ST_ACTIVE));
        end
        else
        begin
            if (s[3])
                s = blink ? ST_RESTORE_BOFF : ST_RESTORE_OFF;
            else
                s = s & (blink ? ST_MASK_BOFF : ST_MASK_OFF);
            if (s[1:0] == 2'b00)
                s = 5'h00;
        end
        return s;
    endfunction

endpackage

// ----- rtl/midi_led_state_blink_manager.sv -----
// ----------------------------------------------------------------------------
// midi_led_state_blink_manager
// per-led state keeper driven by note events, with timed blinking
// ----------------------------------------------------------------------------
// Words are handled one at a time. A note event walks the note map one entry
// per cycle until a match and then updates that led. If the result is not a
// blink-on, it walks the led memory once more to recheck blinking. A tick that
// toggles the phase walks the led memory, rewriting the phase bit of each
// blinking entry with a read-modify-write. Each memory has a single read port.
// No clearing pass: the note map and led state carry per-entry valid bits that
// reset clears at once. The input accepts a new word while a finished result
// waits in the output register.
module midi_led_state_blink_manager
#(
    parameter int LED_COUNT = mlsbm_pkg::LED_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [6:0]  note,
    input  logic [6:0]  velocity,
    input  logic [5:0]  led_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        matched,
    output logic [5:0]  led_number,
    output logic [4:0]  led_state,
    output logic        lit,
    output logic        blink_active,
    output logic        blink_phase
);
    import mlsbm_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] LAST = CW'(LED_COUNT - 1);

    // memories
    logic [7:0] map_mem [LED_COUNT];
    logic [4:0] led_mem [LED_COUNT];
    logic [LED_COUNT-1:0] map_vld_reg;
    logic [LED_COUNT-1:0] led_vld_reg;
    logic [7:0] map_rd_reg;
    logic [4:0] led_rd_reg;
    logic map_rv_reg;
    logic led_rv_reg;

    logic map_we, led_we;
    logic [AW-1:0] map_wa, led_wa, map_ra, led_ra;
    logic [7:0] map_wd;
    logic [4:0] led_wd;

    logic [7:0] map_q;
    logic [4:0] led_q;
    assign map_q = map_rv_reg ? map_rd_reg : MAP_UNASSIGNED;
    assign led_q = led_rv_reg ? led_rd_reg : 5'h00;

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_wa] <= map_wd;
        map_rd_reg <= map_mem[map_ra];
        if (led_we)
            led_mem[led_wa] <= led_wd;
        led_rd_reg <= led_mem[led_ra];
    end

    // config
    logic blink_en_reg;
    logic [15:0] period_reg;
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_en_reg <= 1'b0;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PERIOD[0])
                period_reg <= pwdata[15:0];
            else
                blink_en_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_PERIOD[0])
            prdata = {16'd0, period_reg};
        else if (paddr[2] == REG_BLINK_EN[0])
            prdata = {31'd0, blink_en_reg};
    end

    // control
    ctl_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0] mode_reg, mode_next;
    logic [6:0] note_reg, note_next;
    logic on_reg, on_next, blk_reg, blk_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic hit_ok_reg, hit_ok_next;
    logic [4:0] res_reg, res_next;
    logic any_reg, any_next;
    logic blinking_reg, blinking_next;
    logic phase_reg, phase_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic toggle_reg, toggle_next;
    logic ov_reg, ov_next;
    logic o_m_reg, o_m_next;
    logic [5:0] o_n_reg, o_n_next;
    logic [4:0] o_s_reg, o_s_next;
    logic o_l_reg, o_l_next;
    logic o_b_reg, o_b_next;
    logic o_p_reg, o_p_next;
    logic map_rv_next, led_rv_next;
    logic [LED_COUNT-1:0] map_vld_next, led_vld_next;

    logic accept;
    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;

    logic [15:0] el_inc;
    assign el_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        mode_next = mode_reg;
        note_next = note_reg;
        on_next = on_reg;
        blk_next = blk_reg;
        hit_next = hit_reg;
        hit_ok_next = hit_ok_reg;
        res_next = res_reg;
        any_next = any_reg;
        blinking_next = blinking_reg;
        phase_next = phase_reg;
        elapsed_next = elapsed_reg;
        toggle_next = toggle_reg;
        ov_next = ov_reg && out_stall;
        o_m_next = o_m_reg;
        o_n_next = o_n_reg;
        o_s_next = o_s_reg;
        o_l_next = o_l_reg;
        o_b_next = o_b_reg;
        o_p_next = o_p_reg;
        map_vld_next = map_vld_reg;
        led_vld_next = led_vld_reg;
        map_we = 1'b0;
        map_wa = hit_reg;
        map_wd = {1'b0, note_reg};
        led_we = 1'b0;
        led_wa = hit_reg;
        led_wd = res_reg;
        map_ra = cnt_reg[AW-1:0];
        led_ra = cnt_reg[AW-1:0];
        map_rv_next = map_vld_reg[map_ra];
        led_rv_next = led_vld_reg[led_ra];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    note_next = note;
                    hit_ok_next = 1'b0;
                    any_next = 1'b0;
                    cnt_next = '0;
                    hit_next = AW'(led_index);
                    if (blink_en_reg)
                    begin
                        on_next = !(velocity == 7'd0 || velocity == 7'd63);
                        blk_next = velocity >= 7'd63;
                    end
                    else
                    begin
                        on_next = velocity != 7'd0;
                        blk_next = 1'b0;
                    end
                    map_ra = '0;
                    led_ra = (mode == MODE_READ || mode == MODE_WRITE)
                           ? AW'(led_index) : '0;
                    map_rv_next = map_vld_reg[map_ra];
                    led_rv_next = led_vld_reg[led_ra];
                    case (mode)
                        MODE_EVENT:
                            state_next = S_SCAN;
                        MODE_TICK:
                        begin
                            toggle_next = blinking_reg && blink_en_reg
                                          && el_inc >= period_reg;
                            elapsed_next = toggle_next ? 16'd0 : el_inc;
                            state_next = toggle_next ? S_CHECK : S_OUT;
                        end
                        default:
                        begin
                            if ({2'b00, led_index} < 8'(LED_COUNT))
                            begin
                                hit_ok_next = 1'b1;
                                if (mode == MODE_WRITE)
                                begin
                                    map_we = 1'b1;
                                    map_wa = AW'(led_index);
                                    map_wd = {1'b0, note};
                                    map_vld_next[map_wa] = 1'b1;
                                end
                            end
                            state_next = S_UPD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // map entry cnt is on the read port now
                if (map_q == {1'b0, note_reg})
                begin
                    hit_next = cnt_reg[AW-1:0];
                    hit_ok_next = 1'b1;
                    led_ra = cnt_reg[AW-1:0];
                    led_rv_next = led_vld_reg[led_ra];
                    state_next = S_SCAN_END;
                end
                else if (cnt_reg == LAST)
                    state_next = S_OUT;
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    map_ra = cnt_next[AW-1:0];
                    map_rv_next = map_vld_reg[map_ra];
                end
            end
            S_SCAN_END:
            begin
                res_next = apply_event(led_q, on_reg, blk_reg);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (mode_reg == MODE_EVENT)
                begin
                    led_we = 1'b1;
                    led_vld_next[hit_reg] = 1'b1;
                    if (blk_reg && on_reg)
                    begin
                        blinking_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        any_next = res_reg[1];
                        cnt_next = '0;
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    res_next = led_q;
                    state_next = S_OUT;
                end
            end
            S_CHECK:
            begin
                // walk led memory; on a toggle, rewrite the phase bit
                if (cnt_reg != '0)
                begin
                    if (mode_reg == MODE_TICK)
                    begin
                        if (led_q[1])
                        begin
                            led_we = 1'b1;
                            led_wa = AW'(cnt_reg - 1'b1);
                            led_wd = phase_reg ? (led_q | ST_PHASE)
                                               : (led_q & ST_NO_PHASE);
                            led_vld_next[led_wa] = 1'b1;
                        end
                    end
                    else if (AW'(cnt_reg - 1'b1) != hit_reg && led_q[1])
                        any_next = 1'b1;
                end
                if (cnt_reg == CW'(LED_COUNT))
                begin
                    if (mode_reg == MODE_TICK)
                        phase_next = !phase_reg;
                    else if (any_next)
                        blinking_next = 1'b1;
                    else if (blinking_reg)
                    begin
                        blinking_next = 1'b0;
                        phase_next = 1'b1;
                        elapsed_next = ELAPSED_MAX;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    led_ra = cnt_reg[AW-1:0];
                    led_rv_next = led_vld_reg[led_ra];
                end
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    o_m_next = hit_ok_reg && mode_reg != MODE_TICK;
                    o_n_next = o_m_next ? 6'(hit_reg) : 6'd0;
                    o_s_next = o_m_next ? res_reg : 5'd0;
                    o_l_next = o_m_next && state_lit(res_reg);
                    o_b_next = blinking_reg;
                    o_p_next = phase_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            blinking_reg <= 1'b0;
            phase_reg <= 1'b1;
            elapsed_reg <= ELAPSED_MAX;
            ov_reg <= 1'b0;
            map_vld_reg <= '0;
            led_vld_reg <= '0;
            map_rv_reg <= 1'b0;
            led_rv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            blinking_reg <= blinking_next;
            phase_reg <= phase_next;
            elapsed_reg <= elapsed_next;
            ov_reg <= ov_next;
            map_vld_reg <= map_vld_next;
            led_vld_reg <= led_vld_next;
            map_rv_reg <= map_rv_next;
            led_rv_reg <= led_rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        note_reg <= note_next;
        on_reg <= on_next;
        blk_reg <= blk_next;
        hit_reg <= hit_next;
        hit_ok_reg <= hit_ok_next;
        res_reg <= res_next;
        any_reg <= any_next;
        toggle_reg <= toggle_next;
        o_m_reg <= o_m_next;
        o_n_reg <= o_n_next;
        o_s_reg <= o_s_next;
        o_l_reg <= o_l_next;
        o_b_reg <= o_b_next;
        o_p_reg <= o_p_next;
    end

    assign out_valid = ov_reg;
    assign matched = o_m_reg;
    assign led_number = o_n_reg;
    assign led_state = o_s_reg;
    assign lit = o_l_reg;
    assign blink_active = o_b_reg;
    assign blink_phase = o_p_reg;

endmodule

// ----- tb/led_state_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_state_checker
// watches the input and result channels, predicts each led state result and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module led_state_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [6:0]  note,
    input  logic [6:0]  velocity,
    input  logic [5:0]  led_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        matched,
    input  logic [5:0]  led_number,
    input  logic [4:0]  led_state,
    input  logic        lit,
    input  logic        blink_active,
    input  logic        blink_phase,
    output int          fail_count,
    output int          pending_count
);
    import mlsbm_pkg::*;

    typedef struct packed {
        logic       matched;
        logic [5:0] led_number;
        logic [4:0] led_state;
        logic       lit;
        logic       blink_active;
        logic       blink_phase;
    } led_result_t;

    logic [4:0]  led_mem [64];
    logic [7:0]  map_mem [64];
    logic        blinking;
    logic        phase_pending;
    logic [15:0] elapsed;
    logic        feature_en;
    logic [15:0] period;
    led_result_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic is_lit(input logic [4:0] s);
        return s == 5'h05 || s == 5'h15 || s == 5'h16 || s == 5'h1D
            || s == 5'h0D || s == 5'h17;
    endfunction

    task automatic refresh_blinking();
        logic any;
        any = 1'b0;
        for (int i = 0; i < 64; i++)
            if (led_mem[i][1])
                any = 1'b1;
        if (any)
            blinking = 1'b1;
        else if (blinking)
        begin
            blinking = 1'b0;
            phase_pending = 1'b1;
            elapsed = 16'hFFFF;
        end
    endtask

    task automatic predict_led_result(input logic [1:0] m, input logic [6:0] n,
                                      input logic [6:0] v, input logic [5:0] li);
        led_result_t r;
        int hit;
        logic on;
        logic blink;
        logic [4:0] s;
        hit = -1;
        blink = 1'b0;
        if (m == MODE_EVENT)
        begin
            if (feature_en)
            begin
                on = !(v == 7'd0 || v == 7'd63);
                blink = v >= 7'd63;
            end
            else
                on = v != 7'd0;
            for (int i = 0; i < 64; i++)
                if (hit < 0 && map_mem[i] == {1'b0, n})
                    hit = i;
            if (hit >= 0)
            begin
                s = led_mem[hit];
                if (on)
                begin
                    if (!blink && s[1])
                        s = 5'h0D;
                    else
                        s = s | (blink ? 5'h16 : 5'h05);
                end
                else
                begin
                    if (s[3])
                        s = blink ? 5'h05 : 5'h16;
                    else
                        s = s & (blink ? 5'h15 : 5'h16);
                    if (s[1:0] == 2'b00)
                        s = 5'h00;
                end
                led_mem[hit] = s;
                if (blink && on)
                    blinking = 1'b1;
                else
                    refresh_blinking();
            end
        end
        else if (m == MODE_TICK)
        begin
            if (elapsed != 16'hFFFF)
                elapsed++;
            if (blinking && feature_en && elapsed >= period)
            begin
                for (int i = 0; i < 64; i++)
                    if (led_mem[i][1])
                        led_mem[i][4] = phase_pending;
                phase_pending = !phase_pending;
                elapsed = 16'd0;
            end
        end
        else
        begin
            hit = li;
            if (m == MODE_WRITE)
                map_mem[li] = {1'b0, n};
        end
        r = '0;
        if (hit >= 0)
        begin
            r.matched = 1'b1;
            r.led_number = hit[5:0];
            r.led_state = led_mem[hit];
            r.lit = is_lit(led_mem[hit]);
        end
        r.blink_active = blinking;
        r.blink_phase = phase_pending;
        expected_results.push_back(r);
    endtask

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        led_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 64; i++)
            begin
                led_mem[i] = 5'h00;
                map_mem[i] = MAP_UNASSIGNED;
            end
            blinking = 1'b0;
            phase_pending = 1'b1;
            elapsed = 16'hFFFF;
            feature_en = 1'b0;
            period = PERIOD_RESET;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_PERIOD[0])
                    period = pwdata[15:0];
                else
                    feature_en = pwdata[0];
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    compare_field("matched", e.matched, matched);
                    compare_field("led_number", e.led_number, led_number);
                    compare_field("led_state", e.led_state, led_state);
                    compare_field("lit", e.lit, lit);
                    compare_field("blink_active", e.blink_active, blink_active);
                    compare_field("blink_phase", e.blink_phase, blink_phase);
                end
            end
            if (in_valid && !in_stall)
                predict_led_result(mode, note, velocity, led_index);
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives note events, ticks and map accesses into the led state manager with
// bursty input and random result stalls, across several blink settings
// ----------------------------------------------------------------------------
module testbench;
    import mlsbm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [5:0]  led_index;
    logic        out_valid;
    logic        out_stall;
    logic        matched;
    logic [5:0]  led_number;
    logic [4:0]  led_state;
    logic        lit;
    logic        blink_active;
    logic        blink_phase;
    int          fail_count;
    int          pending_count;
    int          gap_left;
    int          stall_mode;

    midi_led_state_blink_manager dut (.*);

    led_state_checker checker_i (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver stall pattern: phases of none, light, heavy
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx[0], 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_word(input logic [1:0] m, input logic [6:0] n,
                             input logic [6:0] v, input logic [5:0] li);
        if (gap_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            gap_left = $urandom_range(1, 30);
        end
        gap_left--;
        in_valid <= 1'b1;
        mode <= m;
        note <= n;
        velocity <= v;
        led_index <= li;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        // let the checker record the last accepted word
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_words(input int count);
        int k;
        logic [1:0] m;
        logic [6:0] v;
        for (k = 0; k < count; k++)
        begin
            m = $urandom_range(0, 9) < 6 ? MODE_EVENT
              : ($urandom_range(0, 2) == 0 ? MODE_WRITE
              : ($urandom_range(0, 1) ? MODE_TICK : MODE_READ));
            case ($urandom_range(0, 5))
                0: v = 7'd0;
                1: v = 7'd63;
                2: v = 7'($urandom_range(1, 62));
                default: v = 7'($urandom_range(64, 127));
            endcase
            // mostly notes that the map holds, some strays
            send_word(m, $urandom_range(0, 4) == 0 ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, 15)),
                      v, $urandom_range(0, 4) == 0 ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        mode = MODE_EVENT;
        note = '0;
        velocity = '0;
        led_index = '0;
        gap_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: unmapped event, read of the last led while free, map, extremes
        send_word(MODE_EVENT, 7'd127, 7'd127, 6'd63);
        send_word(MODE_READ, 7'd0, 7'd0, 6'd63);
        send_word(MODE_WRITE, 7'd127, 7'd0, 6'd63);
        send_word(MODE_WRITE, 7'd127, 7'd0, 6'd5);
        send_word(MODE_EVENT, 7'd127, 7'd127, 6'd0);
        send_word(MODE_READ, 7'd0, 7'd0, 6'd5);
        send_word(MODE_EVENT, 7'd127, 7'd0, 6'd0);
        send_word(MODE_TICK, 7'd0, 7'd0, 6'd0);
        wait_idle();
        write_reg(REG_BLINK_EN, 32'd1);
        write_reg(REG_PERIOD, 32'd0);
        send_word(MODE_WRITE, 7'd0, 7'd0, 6'd0);
        send_word(MODE_EVENT, 7'd0, 7'd64, 6'd0);
        send_word(MODE_TICK, 7'd0, 7'd0, 6'd0);
        send_word(MODE_TICK, 7'd0, 7'd0, 6'd0);
        send_word(MODE_EVENT, 7'd0, 7'd1, 6'd0);
        send_word(MODE_EVENT, 7'd0, 7'd63, 6'd0);
        send_word(MODE_EVENT, 7'd0, 7'd62, 6'd0);
        send_word(MODE_EVENT, 7'd0, 7'd0, 6'd0);
        send_word(MODE_EVENT, 7'd127, 7'd127, 6'd0);
        wait_idle();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BLINK_EN, ph == 5 ? 32'd0 : 32'd1);
            case (ph)
                0: write_reg(REG_PERIOD, 32'd1);
                1: write_reg(REG_PERIOD, 32'd3);
                2: write_reg(REG_PERIOD, 32'd65535);
                3: write_reg(REG_PERIOD, 32'd0);
                default: write_reg(REG_PERIOD, $urandom_range(0, 8));
            endcase
            random_words(300);
            wait_idle();
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
